/* src/pssw_pkg.sv */
// pssw_pkg: shared types, constants and byte functions of the PNG stored-stream writer.
// No dependencies; imported by pssw_front, pssw_back, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package pssw_pkg;

	typedef logic [5:0] idx_t;

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Byte positions inside the file header burst
	localparam idx_t HDR_IHDR = 6'd12;
	localparam idx_t HDR_W    = 6'd16;
	localparam idx_t HDR_H    = 6'd20;
	localparam idx_t HDR_FIX  = 6'd24;
	localparam idx_t HDR_CRC  = 6'd29;
	localparam idx_t HDR_LEN  = 6'd33;
	localparam idx_t HDR_IDAT = 6'd37;
	localparam idx_t HDR_LAST = 6'd42;

	// Byte positions inside the trailer burst
	localparam idx_t TRL_CRC  = 6'd4;
	localparam idx_t TRL_ZERO = 6'd8;
	localparam idx_t TRL_IEND = 6'd12;
	localparam idx_t TRL_CRC2 = 6'd16;
	localparam idx_t TRL_LAST = 6'd19;

	localparam idx_t BH_LAST  = 6'd4;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	typedef struct packed {
		logic start;      // first pixel byte of a file
		logic row_start;  // filter byte goes in front
		logic last;       // completes the image
	} item_ctl_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} beat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] s);
		logic [7:0] r;
		case (s)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	// fixed bytes of the header burst (variable positions read as zero)
	function automatic logic [7:0] hdr_const(input idx_t i);
		logic [7:0] r;
		case (i)
			6'd0: r = 8'd137;
			6'd1: r = 8'd80;
			6'd2: r = 8'd78;
			6'd3: r = 8'd71;
			6'd4: r = 8'd13;
			6'd5: r = 8'd10;
			6'd6: r = 8'd26;
			6'd7: r = 8'd10;
			6'd11: r = 8'd13;
			6'd12: r = 8'h49;
			6'd13: r = 8'h48;
			6'd14: r = 8'h44;
			6'd15: r = 8'h52;
			6'd24: r = 8'd8;
			6'd25: r = 8'd6;
			6'd37: r = 8'h49;
			6'd38: r = 8'h44;
			6'd39: r = 8'h41;
			6'd40: r = 8'h54;
			6'd41: r = 8'h78;
			6'd42: r = 8'h01;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] iend_byte(input logic [1:0] s);
		logic [7:0] r;
		case (s)
			2'd0: r = 8'h49;
			2'd1: r = 8'h45;
			2'd2: r = 8'h4E;
			default: r = 8'h44;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/pssw_fifo.sv */
// pssw_fifo: small register queue with full/empty flags.
// No dependencies; used for the item queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module pssw_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* src/pssw_div.sv */
// pssw_div: division by a constant through a reciprocal multiply, four partial products.
// No dependencies; used by pssw_back for the stored block count.
`timescale 1ns / 1ps
`default_nettype none
module pssw_div #(
	parameter int W       = 34,
	parameter int DIVISOR = 65535
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	output logic              done,
	output logic [W-1:0]      quot
);
	// quot = (x * M) >> S with M = ceil(2^S / DIVISOR), exact for every x below 2^W
	localparam int L  = $clog2(DIVISOR);
	localparam int S  = W + L;
	localparam int HW = (W + 2) / 2;
	localparam int PW = 2 * HW;
	localparam logic [63:0] RECIP = ((64'd1 << S) + 64'(DIVISOR - 1)) / 64'(DIVISOR);

	logic [PW-1:0]   x_q, m, pp;
	logic [2*PW-1:0] acc_q, pp_ext;
	logic [2:0]      step_q;
	logic [1:0]      sel;
	logic [HW-1:0]   op_a, op_b;
	logic            done_q;

	assign m    = PW'(RECIP);
	assign sel  = 2'(step_q - 3'd1);
	assign op_a = sel[0] ? x_q[PW-1:HW] : x_q[HW-1:0];
	assign op_b = sel[1] ? m[PW-1:HW] : m[HW-1:0];
	assign pp   = op_a * op_b;
	assign done = done_q;
	assign quot = W'(acc_q >> S);

	always_comb begin
		pp_ext = (2*PW)'(pp);
		if (sel[0] && sel[1]) begin
			pp_ext = pp_ext << PW;
		end else if (sel[0] || sel[1]) begin
			pp_ext = pp_ext << HW;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= PW'(dividend);
			acc_q <= '0;
		end else if (step_q != '0) begin
			acc_q <= acc_q + pp_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= 3'd4;
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			if (step_q == 3'd1) begin
				done_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* src/pssw_front.sv */
// pssw_front: classifies each accepted pixel byte (file start, row start, last).
// Depends on pssw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pssw_front import pssw_pkg::*; #(
	parameter int MAX_DIM = 16384,
	parameter int DIM_W   = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             acc,
	input  wire logic [14:0]      cfg_w,
	input  wire logic [14:0]      cfg_h,
	output item_ctl_t             ctl,
	output logic [DIM_W-1:0]      w,
	output logic [DIM_W-1:0]      h
);
	localparam int CMP_W = ((DIM_W > 15) ? DIM_W : 15) + 1;
	localparam int ROW_W = DIM_W + 2;

	function automatic logic [DIM_W-1:0] clamp(input logic [14:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	logic             hdr_q;
	logic [ROW_W-1:0] rb_q, row_left_q, rb, rl_n;
	logic [DIM_W-1:0] rows_q, rows_base, rows_n;
	logic             start, row_start;

	assign w         = clamp(cfg_w);
	assign h         = clamp(cfg_h);
	assign start     = !hdr_q;
	assign rb        = start ? {w, 2'b00} : rb_q;
	assign row_start = start || (row_left_q == '0);
	assign rows_base = start ? h : rows_q;
	assign rows_n    = row_start ? rows_base - 1'b1 : rows_base;
	assign rl_n      = (row_start ? rb : row_left_q) - 1'b1;

	assign ctl.start     = start;
	assign ctl.row_start = row_start;
	assign ctl.last      = (rl_n == '0) && (rows_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q      <= 1'b0;
			rb_q       <= ROW_W'(4);
			row_left_q <= '0;
			rows_q     <= '0;
		end else if (acc) begin
			hdr_q      <= !ctl.last;
			rb_q       <= rb;
			row_left_q <= rl_n;
			rows_q     <= rows_n;
		end
	end
endmodule
`default_nettype wire

/* src/pssw_back.sv */
// pssw_back: byte sequencer; header, block headers, raw bytes, trailer, CRC and Adler.
// Depends on pssw_pkg and pssw_div.
`timescale 1ns / 1ps
`default_nettype none
module pssw_back import pssw_pkg::*; #(
	parameter int DIM_W   = 15,
	parameter int BLK_CAP = 65535
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             hd_valid,
	input  wire item_ctl_t        hd_ctl,
	input  wire logic [7:0]       hd_px,
	input  wire logic [DIM_W-1:0] hd_w,
	input  wire logic [DIM_W-1:0] hd_h,
	output logic                  hd_pop,
	input  wire logic             out_space,
	output logic                  out_push,
	output beat_t                 out_beat
);
	localparam int RAW_W = 2 * DIM_W + 2;
	localparam int DIV_W = RAW_W + 1;
	localparam int LEN_W = (DIV_W + 3 > 32) ? DIV_W + 3 : 32;

	typedef enum logic [1:0] {PH_NEXT, PH_HDR, PH_RAW, PH_TRL} phase_t;

	phase_t           phase_q, cur_phase;
	idx_t             idx_q, cur_idx;
	logic             filt_q, cur_filt;
	logic [31:0]      crc_q, crc_src, crc_nxt;
	logic [15:0]      adl_a_q, adl_b_q;
	logic [16:0]      a_sum, a_n, b_sum, b_n;
	logic [15:0]      blk_q, blk_sz;
	logic [RAW_W-1:0] raw_left_q, raw_q, raw_prod;
	logic             div_done, len_wait, go, feed, crc_rst, bfinal;
	logic [DIV_W-1:0] quot;
	logic [LEN_W-1:0] idat_len;
	logic [7:0]       raw_b, obyte;
	logic [1:0]       sel;

	pssw_div #(.W(DIV_W), .DIVISOR(BLK_CAP)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (phase_q == PH_HDR && idx_q == 6'd1),
		.dividend (DIV_W'(raw_q) + DIV_W'(BLK_CAP - 1)),
		.done     (div_done),
		.quot     (quot)
	);

	assign raw_prod  = {hd_w, 2'b01} * hd_h;
	assign idat_len  = LEN_W'(raw_q) + LEN_W'({quot, 2'b00}) + LEN_W'(quot) + LEN_W'(6);

	assign cur_phase = (phase_q == PH_NEXT) ? (hd_ctl.start ? PH_HDR : PH_RAW) : phase_q;
	assign cur_idx   = (phase_q == PH_NEXT) ? '0 : idx_q;
	assign cur_filt  = (phase_q == PH_NEXT) ? hd_ctl.row_start : filt_q;
	assign raw_b     = cur_filt ? 8'd0 : hd_px;

	assign len_wait  = (cur_phase == PH_HDR) && (cur_idx >= HDR_LEN) &&
	                   (cur_idx < HDR_IDAT) && !div_done;
	assign go        = hd_valid && out_space && !len_wait;

	assign blk_sz = (raw_left_q < RAW_W'(BLK_CAP)) ? raw_left_q[15:0] : 16'(BLK_CAP);
	assign bfinal = (raw_left_q <= RAW_W'(BLK_CAP));

	assign a_sum = {1'b0, adl_a_q} + {9'd0, raw_b};
	assign a_n   = (a_sum >= ADLER_MOD) ? a_sum - ADLER_MOD : a_sum;
	assign b_sum = {1'b0, adl_b_q} + {1'b0, a_n[15:0]};
	assign b_n   = (b_sum >= ADLER_MOD) ? b_sum - ADLER_MOD : b_sum;

	always_comb begin
		obyte   = 8'd0;
		feed    = 1'b0;
		crc_rst = 1'b0;
		out_beat.last = 1'b0;
		out_beat.done = 1'b0;
		hd_pop  = 1'b0;
		sel     = 2'd0;
		case (cur_phase)
			PH_HDR: begin
				crc_rst = (cur_idx == HDR_IHDR) || (cur_idx == HDR_IDAT);
				feed    = ((cur_idx >= HDR_IHDR) && (cur_idx < HDR_CRC)) ||
				          (cur_idx >= HDR_IDAT);
				if (cur_idx >= HDR_W && cur_idx < HDR_H) begin
					sel   = 2'(cur_idx - HDR_W);
					obyte = be_byte(32'(hd_w), sel);
				end else if (cur_idx >= HDR_H && cur_idx < HDR_FIX) begin
					sel   = 2'(cur_idx - HDR_H);
					obyte = be_byte(32'(hd_h), sel);
				end else if (cur_idx >= HDR_CRC && cur_idx < HDR_LEN) begin
					sel   = 2'(cur_idx - HDR_CRC);
					obyte = be_byte(~crc_q, sel);
				end else if (cur_idx >= HDR_LEN && cur_idx < HDR_IDAT) begin
					sel   = 2'(cur_idx - HDR_LEN);
					obyte = be_byte(idat_len[31:0], sel);
				end else begin
					obyte = hdr_const(cur_idx);
				end
			end
			PH_RAW: begin
				feed = 1'b1;
				if (blk_q == '0) begin
					case (cur_idx[2:0])
						3'd0: obyte = {7'd0, bfinal};
						3'd1: obyte = blk_sz[7:0];
						3'd2: obyte = blk_sz[15:8];
						3'd3: obyte = ~blk_sz[7:0];
						default: obyte = ~blk_sz[15:8];
					endcase
				end else begin
					obyte = raw_b;
					if (!cur_filt && !hd_ctl.last) begin
						out_beat.last = 1'b1;
						hd_pop        = go;
					end
				end
			end
			PH_TRL: begin
				sel = cur_idx[1:0];
				if (cur_idx < TRL_CRC) begin
					feed  = 1'b1;
					obyte = be_byte({adl_b_q, adl_a_q}, sel);
				end else if (cur_idx < TRL_ZERO) begin
					obyte = be_byte(~crc_q, sel);
				end else if (cur_idx < TRL_IEND) begin
					obyte = 8'd0;
				end else if (cur_idx < TRL_CRC2) begin
					feed    = 1'b1;
					crc_rst = (cur_idx == TRL_IEND);
					obyte   = iend_byte(sel);
				end else begin
					obyte = be_byte(~crc_q, sel);
				end
				if (cur_idx == TRL_LAST) begin
					out_beat.last = 1'b1;
					out_beat.done = 1'b1;
					hd_pop        = go;
				end
			end
			default: begin
				obyte = 8'd0;
			end
		endcase
		out_beat.data = obyte;
	end

	assign crc_src       = crc_rst ? CRC_INIT : crc_q;
	assign crc_nxt       = feed ? crc_byte(crc_src, obyte) : crc_q;
	assign out_push      = go;

	always_ff @(posedge clk) begin
		if (go && cur_phase == PH_HDR && cur_idx == '0) begin
			raw_q <= raw_prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NEXT;
			idx_q      <= '0;
			filt_q     <= 1'b0;
			crc_q      <= CRC_INIT;
			adl_a_q    <= 16'd1;
			adl_b_q    <= 16'd0;
			blk_q      <= '0;
			raw_left_q <= '0;
		end else if (go) begin
			crc_q <= crc_nxt;
			case (cur_phase)
				PH_HDR: begin
					if (cur_idx == HDR_LAST) begin
						phase_q    <= PH_RAW;
						idx_q      <= '0;
						filt_q     <= hd_ctl.row_start;
						raw_left_q <= raw_q;
						blk_q      <= '0;
						adl_a_q    <= 16'd1;
						adl_b_q    <= 16'd0;
					end else begin
						phase_q <= PH_HDR;
						idx_q   <= cur_idx + 1'b1;
					end
				end
				PH_RAW: begin
					if (blk_q == '0) begin
						phase_q <= PH_RAW;
						filt_q  <= cur_filt;
						if (cur_idx == BH_LAST) begin
							blk_q <= blk_sz;
							idx_q <= '0;
						end else begin
							idx_q <= cur_idx + 1'b1;
						end
					end else begin
						adl_a_q    <= a_n[15:0];
						adl_b_q    <= b_n[15:0];
						blk_q      <= blk_q - 1'b1;
						raw_left_q <= raw_left_q - 1'b1;
						idx_q      <= '0;
						filt_q     <= 1'b0;
						if (cur_filt) begin
							phase_q <= PH_RAW;
						end else begin
							phase_q <= hd_ctl.last ? PH_TRL : PH_NEXT;
						end
					end
				end
				PH_TRL: begin
					if (cur_idx == TRL_LAST) begin
						phase_q <= PH_NEXT;
						idx_q   <= '0;
					end else begin
						phase_q <= PH_TRL;
						idx_q   <= cur_idx + 1'b1;
					end
				end
				default: begin
					phase_q <= PH_NEXT;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/png_stored_stream_writer.sv */
// png_stored_stream_writer: top level; config registers, item queue, front, back, result queue.
// Depends on pssw_pkg, pssw_fifo, pssw_front, pssw_back (and pssw_div below it).
//
// Usage: push RGBA bytes (R G B A per pixel, raster order) with push while full is low.
// The block writes a complete PNG file (signature, IHDR, one IDAT holding a zlib stream
// of stored deflate blocks, IEND) as bytes on out_byte; take them with pop while empty
// is low. last_of_run marks the last byte caused by one input transaction, file_done
// the final byte of the file. The input that completes the image closes the file; the
// next input starts a new one with the registers as they stand then.
// Config: wr_en/wr_index/wr_data write image_width (index 0) or image_height (index 1);
// write only while the block is idle. Both reset to 1; 0 acts as 1, values above
// MAX_DIMENSION act as MAX_DIMENSION.
// Timing: the result side moves one byte per cycle while pop is high and empty is low;
// the sequencer emits one per cycle unless the item queue is empty, the result queue is
// full or the IDAT length is not ready. An input transaction causes 1 byte for a plain
// pixel byte, 2 at a row start, 5 more at a stored block boundary, 43 more at file start
// and 20 more for the image's last byte. The IDAT length uses a block count from a
// reciprocal multiply (four partial products), ready long before its bytes are due.
// A 4-entry item queue decouples the input from the sequencer, so input keeps flowing
// while the sequencer works or the receiver stalls; when the receiver stops popping,
// the result queue fills, the sequencer halts, then the item queue fills and full rises.
// Reset (arst_n low) clears all queues and control state; the next input starts a file.
`timescale 1ns / 1ps
`default_nettype none
module png_stored_stream_writer import pssw_pkg::*; #(
	parameter int MAX_DIMENSION      = 16384,
	parameter int STORED_BLOCK_LIMIT = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  pixel_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             file_done,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [14:0] wr_data
);
	localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
	localparam int BLK_CAP = (STORED_BLOCK_LIMIT < 2) ? 2 : STORED_BLOCK_LIMIT;
	localparam int CTL_W   = $bits(item_ctl_t);
	localparam int QW      = CTL_W + 8 + 2 * DIM_W;
	localparam int BW      = $bits(beat_t);

	logic [14:0]      width_q, height_q;
	logic             acc;
	item_ctl_t        f_ctl, hd_ctl;
	logic [DIM_W-1:0] f_w, f_h, hd_w, hd_h;
	logic [QW-1:0]    q_din, q_dout;
	logic             q_empty, hd_pop;
	logic [7:0]       hd_px;
	logic             out_full, out_push;
	beat_t            beat, out_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 15'd1;
			height_q <= 15'd1;
		end else if (wr_en) begin
			if (wr_index == REG_WIDTH) begin
				width_q <= wr_data;
			end
			if (wr_index == REG_HEIGHT) begin
				height_q <= wr_data;
			end
		end
	end

	assign acc = push && !full;

	pssw_front #(.MAX_DIM(MAX_DIMENSION), .DIM_W(DIM_W)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.cfg_w  (width_q),
		.cfg_h  (height_q),
		.ctl    (f_ctl),
		.w      (f_w),
		.h      (f_h)
	);

	assign q_din = {f_ctl, pixel_byte, f_w, f_h};

	// item queue between front and back
	pssw_fifo #(.W(QW), .DEPTH(4)) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (acc),
		.din    (q_din),
		.full   (full),
		.pop    (hd_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {hd_ctl, hd_px, hd_w, hd_h} = q_dout;

	pssw_back #(.DIM_W(DIM_W), .BLK_CAP(BLK_CAP)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hd_valid  (!q_empty),
		.hd_ctl    (hd_ctl),
		.hd_px     (hd_px),
		.hd_w      (hd_w),
		.hd_h      (hd_h),
		.hd_pop    (hd_pop),
		.out_space (!out_full),
		.out_push  (out_push),
		.out_beat  (beat)
	);

	// result queue: lets the sequencer run while the receiver stalls
	pssw_fifo #(.W(BW), .DEPTH(4)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (beat),
		.full   (out_full),
		.pop    (pop),
		.dout   (out_head),
		.empty  (empty)
	);

	assign out_byte    = out_head.data;
	assign last_of_run = out_head.last;
	assign file_done   = out_head.done;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full) else $error("result pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		hd_pop |-> !q_empty) else $error("item popped from empty queue");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && file_done) |-> last_of_run) else $error("file end not run end");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		hd_pop |-> (out_push && beat.last)) else $error("item retired without run end");
endmodule
`default_nettype wire

/* dv/tb_png_stored_stream_writer.sv */
// tb_png_stored_stream_writer: self-checking testbench of the PNG stored-stream writer.
// Depends on pssw_pkg and png_stored_stream_writer; predicts every file byte in-line.
`timescale 1ns / 1ps
`default_nettype none
module tb_png_stored_stream_writer;
	import pssw_pkg::*;

	localparam int MAX_DIM    = 16384;
	localparam int BLOCK_CAP  = 65535;
	localparam int CYCLE_CAP  = 200000;
	localparam int SETTLE     = 60;     // idle wait after the last predicted byte is checked

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       done;
	} file_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  pixel_byte = '0;
	logic        pop = 1'b0;
	logic        wr_en = 1'b0;
	logic        wr_index = REG_WIDTH;
	logic [14:0] wr_data = '0;
	logic        full, empty, last_of_run, file_done;
	logic [7:0]  out_byte;

	png_stored_stream_writer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel_byte(pixel_byte),
		.empty(empty), .pop(pop), .out_byte(out_byte), .last_of_run(last_of_run),
		.file_done(file_done), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// Predicted file bytes, oldest first
	file_byte_t file_q[$];

	// Model state: registers, chunk CRC, Adler sums and position in the image
	logic [14:0] reg_w = 15'd1, reg_h = 15'd1;
	logic [31:0] crc_acc = CRC_INIT;
	logic [31:0] adl_lo = 1, adl_hi = 0;
	int          row_left = 0, rows_left = 0, blk_left = 0, row_len = 4;
	longint      raw_left = 0;
	bit          in_file = 0;

	int errors = 0, files_done = 0, items_sent = 0, bytes_checked = 0;
	int tx_idle = 0, rx_idle = 0;       // percent chance of idling: tx before each pixel, rx at each pop decision
	int n_step = 0;                      // bytes predicted for the current transaction

	initial forever #6 clk = ~clk;

	function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
		c ^= {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	function automatic int clamp_dim(logic [14:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic void emit(logic [7:0] b, bit feed);
		file_byte_t fb;
		fb.data = b;
		fb.last = 1'b0;
		fb.done = 1'b0;
		file_q.insert(file_q.size(), fb);
		n_step++;
		if (feed) crc_acc = crc_next(crc_acc, b);
	endfunction

	function automatic void emit_be32(logic [31:0] v, bit feed);
		for (int s = 3; s >= 0; s--) emit(v[s*8 +: 8], feed);
	endfunction

	function automatic void emit_type(logic [31:0] tag);
		crc_acc = CRC_INIT;
		emit_be32(tag, 1'b1);
	endfunction

	function automatic void open_file();
		int w, h;
		longint raw, nblk;
		logic [7:0] sig[8] = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
		w = clamp_dim(reg_w);
		h = clamp_dim(reg_h);
		foreach (sig[i]) emit(sig[i], 1'b0);
		emit_be32(32'd13, 1'b0);
		emit_type("IHDR");
		emit_be32(w, 1'b1);
		emit_be32(h, 1'b1);
		emit(8'd8, 1'b1);
		emit(8'd6, 1'b1);
		emit(8'd0, 1'b1);
		emit(8'd0, 1'b1);
		emit(8'd0, 1'b1);
		emit_be32(~crc_acc, 1'b0);
		row_len = 4 * w;
		raw = longint'(row_len + 1) * h;
		nblk = (raw + BLOCK_CAP - 1) / BLOCK_CAP;
		emit_be32(32'(2 + 5 * nblk + raw + 4), 1'b0);
		emit_type("IDAT");
		emit(8'h78, 1'b1);
		emit(8'h01, 1'b1);
		rows_left = h;
		row_left = 0;
		blk_left = 0;
		raw_left = raw;
		adl_lo = 1;
		adl_hi = 0;
		in_file = 1;
	endfunction

	// One byte of the zlib payload, with a stored block header when a block opens
	function automatic void emit_raw(logic [7:0] b);
		int blk;
		if (blk_left == 0) begin
			blk = (raw_left < BLOCK_CAP) ? int'(raw_left) : BLOCK_CAP;
			emit((raw_left <= BLOCK_CAP) ? 8'd1 : 8'd0, 1'b1);
			emit(blk[7:0], 1'b1);
			emit(blk[15:8], 1'b1);
			emit(~blk[7:0], 1'b1);
			emit(~blk[15:8], 1'b1);
			blk_left = blk;
		end
		emit(b, 1'b1);
		adl_lo += b;
		if (adl_lo >= 65521) adl_lo -= 65521;
		adl_hi += adl_lo;
		if (adl_hi >= 65521) adl_hi -= 65521;
		blk_left--;
		if (raw_left > 0) raw_left--;
	endfunction

	// Expected file bytes caused by one accepted pixel byte
	function automatic void predict_file_bytes(logic [7:0] px);
		n_step = 0;
		if (!in_file) open_file();
		if (row_left == 0) begin
			if (rows_left > 0) rows_left--;
			row_left = row_len;
			emit_raw(8'd0);       // filter type None
		end
		emit_raw(px);
		if (row_left > 0) row_left--;
		if (raw_left == 0) begin
			emit_be32({adl_hi[15:0], adl_lo[15:0]}, 1'b1);
			emit_be32(~crc_acc, 1'b0);
			emit_be32(32'd0, 1'b0);
			emit_type("IEND");
			emit_be32(~crc_acc, 1'b0);
			crc_acc = CRC_INIT;
			in_file = 0;
			file_q[$].done = 1'b1;
		end
		file_q[$].last = 1'b1;
	endfunction

	// Receiver: random pop, driven at the clock edge
	always @(posedge clk)
		pop <= ($urandom_range(99) >= rx_idle);

	// Result checker: compare each popped byte with the oldest prediction
	always @(posedge clk) begin
		file_byte_t e;
		if (arst_n && pop && !empty) begin
			if (file_q.size() == 0) begin
				$error("unexpected byte out_byte=%0h", out_byte);
				errors++;
			end else begin
				e = file_q.pop_front();
				bytes_checked++;
				if (out_byte !== e.data) begin
					$error("out_byte exp %0h got %0h", e.data, out_byte);
					errors++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run exp %0b got %0b", e.last, last_of_run);
					errors++;
				end
				if (file_done !== e.done) begin
					$error("file_done exp %0b got %0b", e.done, file_done);
					errors++;
				end
				if (e.done) files_done++;
			end
		end
	end

	// Watchdog
	initial begin
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_CAP) begin
			@(posedge clk);
			cyc++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Sends one pixel byte; push stays high after acceptance until the next call or drain
	task automatic send_pixel(logic [7:0] b);
		if ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		push <= 1'b1;
		pixel_byte <= b;
		do @(posedge clk); while (full);
		predict_file_bytes(b);
		items_sent++;
	endtask

	// Stop sending and let every predicted byte come out, then let the block settle
	task automatic drain();
		push <= 1'b0;
		while (file_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Only called at file boundaries with the block idle
	task automatic write_dims(logic [14:0] w, logic [14:0] h);
		wr_en <= 1'b1;
		wr_index <= REG_WIDTH;
		wr_data <= w;
		@(posedge clk);
		wr_index <= REG_HEIGHT;
		wr_data <= h;
		@(posedge clk);
		wr_en <= 1'b0;
		reg_w = w;
		reg_h = h;
	endtask

	task automatic send_image(int count);
		for (int i = 0; i < count; i++) send_pixel(8'($urandom_range(255)));
	endtask

	// Reset values: a 1x1 file, data bytes at the extremes and alternating bit patterns
	task automatic test_reset_dims();
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'hAA);
		send_pixel(8'h55);
		drain();
	endtask

	// Two rows of two pixels with walking bits; zero dimensions clamp to one
	task automatic test_small_rows();
		write_dims(15'd2, 15'd2);
		for (int i = 0; i < 16; i++) send_pixel(8'(1 << (i % 8)) ^ ((i >= 8) ? 8'hFF : 8'h00));
		drain();
		write_dims(15'd0, 15'd0);
		send_image(4);
		drain();
	endtask

	// Back-to-back files of random small size under the current idle mix
	task automatic test_random_files(int target);
		int start, w, h;
		start = items_sent;
		while (items_sent - start < target) begin
			w = $urandom_range(3, 1);
			h = $urandom_range(2, 1);
			write_dims(15'(w), 15'(h));
			send_image(4 * w * h);
			if ($urandom_range(1)) send_image(4 * w * h);  // second file, same registers
			drain();
		end
	endtask

	// Over-range sizes clamp in IHDR; the IDAT length counts thousands of stored blocks
	// and the first block is not final. Only the head of that file is sent.
	task automatic test_big_headers();
		tx_idle = 0;
		rx_idle = 0;
		write_dims(15'h7FFF, 15'h7FFF);
		send_image(8);
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 23;
		rx_idle = 80;
		test_reset_dims();
		test_small_rows();
		test_random_files(55);
		tx_idle = 80;
		rx_idle = 23;
		test_random_files(55);
		tx_idle = 0;
		rx_idle = 0;
		test_random_files(55);
		test_big_headers();
		$display("Sent %0d pixel bytes, checked %0d file bytes over %0d files,",
			items_sent, bytes_checked, files_done);
		$display("covering clamped sizes, multi-row images and a maximum-size file header.");
		if (errors == 0 && file_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
